>>> hw/rtl/lrgb_pkg.sv
// Shared types and plot geometry constants for the line walker with grid background.
// Used by lrgb_color and line_restore_with_grid_background.
`default_nettype none

package lrgb_pkg;

	localparam int PLOT_LEFT   = 8;
	localparam int PLOT_TOP    = 40;
	localparam int PLOT_WIDTH  = 300;
	localparam int PLOT_HEIGHT = 164;

	localparam int X_W     = 9;
	localparam int Y_W     = 8;
	localparam int COLOR_W = 16;
	localparam int ERR_W   = 11;
	localparam int CFG_IDX_W = 2;

	localparam int AXIS_X = PLOT_LEFT + PLOT_WIDTH / 2;
	localparam int AXIS_Y = PLOT_TOP + PLOT_HEIGHT / 2;

	localparam int NUM_GRID_X = 4;
	localparam int NUM_GRID_Y = 3;

	localparam int GRID_X [NUM_GRID_X] = '{
		PLOT_LEFT + 1 + (1 * (PLOT_WIDTH - 3)) / 5,
		PLOT_LEFT + 1 + (2 * (PLOT_WIDTH - 3)) / 5,
		PLOT_LEFT + 1 + (3 * (PLOT_WIDTH - 3)) / 5,
		PLOT_LEFT + 1 + (4 * (PLOT_WIDTH - 3)) / 5
	};

	localparam int GRID_Y [NUM_GRID_Y] = '{
		PLOT_TOP + 1 + (1 * (PLOT_HEIGHT - 3)) / 4,
		PLOT_TOP + 1 + (2 * (PLOT_HEIGHT - 3)) / 4,
		PLOT_TOP + 1 + (3 * (PLOT_HEIGHT - 3)) / 4
	};

	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_NEXT  = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_COLOR = 2'd0,
		REG_GRID_COLOR = 2'd1,
		REG_BACK_COLOR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [COLOR_W-1:0] axis;
		logic [COLOR_W-1:0] grid;
		logic [COLOR_W-1:0] back;
	} colors_t;

	localparam logic [COLOR_W-1:0] AXIS_COLOR_RST = 16'd31;
	localparam logic [COLOR_W-1:0] GRID_COLOR_RST = 16'd12874;
	localparam logic [COLOR_W-1:0] BACK_COLOR_RST = 16'd0;

endpackage

`default_nettype wire

>>> hw/rtl/lrgb_color.sv
// Background color lookup for one pixel: axis, grid line or empty plot.
// Depends on lrgb_pkg for plot geometry and the color register struct.
`default_nettype none

module lrgb_color
	import lrgb_pkg::*;
(
	input  wire logic [X_W-1:0]     x,
	input  wire logic [Y_W-1:0]     y,
	input  wire colors_t            colors,
	output logic      [COLOR_W-1:0] color
);

	logic on_axis;
	logic on_grid;

	always_comb begin
		on_axis = (int'(x) == AXIS_X) || (int'(y) == AXIS_Y);
		on_grid = 1'b0;
		for (int i = 0; i < NUM_GRID_X; i++) begin
			if (int'(x) == GRID_X[i]) begin
				on_grid = 1'b1;
			end
		end
		for (int i = 0; i < NUM_GRID_Y; i++) begin
			if (int'(y) == GRID_Y[i]) begin
				on_grid = 1'b1;
			end
		end
		if (on_axis) begin
			color = colors.axis;
		end else if (on_grid) begin
			color = colors.grid;
		end else begin
			color = colors.back;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/line_restore_with_grid_background.sv
// Line walker giving one result per request: pixel and restored grid background color.
// Depends on lrgb_pkg and lrgb_color.
//
// Usage:
//   Request channel (cmd_valid/cmd_ready): command START loads start_x/y and
//   end_x/y and emits the start pixel; command NEXT takes one Bresenham step
//   and emits that pixel. NEXT with no line in progress gives a result with
//   pixel_valid low and all other fields zero.
//   Result channel (res_valid/res_ready): exactly one result per request.
//   last_pixel marks the pixel that reaches the line end; the walker is then idle.
//   The result is registered when the request is taken and shows in the next cycle.
//   Throughput: one request per cycle while res_ready drains the result. The walker
//   state and the error term are updated in the accept cycle, with the color lookup
//   in the same path, so the next request sees the new position at once.
//   Stall: a single output register holds the result; cmd_ready stays high while
//   that register is empty or being drained in the same cycle.
//   Reset: no line in progress, output empty, colors at their defaults.
//   Config: cfg_we writes cfg_data into the color selected by cfg_index
//   (0 axis, 1 grid, 2 back); write only while no request is in flight.
`default_nettype none

module line_restore_with_grid_background
	import lrgb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data,

	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire logic                 command,
	input  wire logic [X_W-1:0]       start_x,
	input  wire logic [Y_W-1:0]       start_y,
	input  wire logic [X_W-1:0]       end_x,
	input  wire logic [Y_W-1:0]       end_y,

	output logic                      res_valid,
	input  wire logic                 res_ready,
	output logic      [X_W-1:0]       pixel_x,
	output logic      [Y_W-1:0]       pixel_y,
	output logic      [COLOR_W-1:0]   pixel_color,
	output logic                      pixel_valid,
	output logic                      last_pixel
);

	// configuration
	colors_t colors_q;

	// walker state
	logic [X_W-1:0]   cur_x_q,  goal_x_q, span_x_q;
	logic [Y_W-1:0]   cur_y_q,  goal_y_q, span_y_q;
	logic             step_x_neg_q, step_y_neg_q;
	logic [ERR_W-1:0] err_q;
	logic             active_q;

	// next walker state
	logic [X_W-1:0]   cur_x_d,  goal_x_d, span_x_d;
	logic [Y_W-1:0]   cur_y_d,  goal_y_d, span_y_d;
	logic             step_x_neg_d, step_y_neg_d;
	logic [ERR_W-1:0] err_d;
	logic             emit;
	logic             last;

	logic signed [ERR_W:0] err_ext, e2, err_acc;
	logic signed [ERR_W:0] span_x_s, span_y_s;

	logic [COLOR_W-1:0] color;

	// result register
	logic               res_valid_q;
	logic [X_W-1:0]     res_x_q;
	logic [Y_W-1:0]     res_y_q;
	logic [COLOR_W-1:0] res_color_q;
	logic               res_pv_q;
	logic               res_last_q;

	logic accept;

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colors_q.axis <= AXIS_COLOR_RST;
			colors_q.grid <= GRID_COLOR_RST;
			colors_q.back <= BACK_COLOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS_COLOR: colors_q.axis <= cfg_data;
				REG_GRID_COLOR: colors_q.grid <= cfg_data;
				REG_BACK_COLOR: colors_q.back <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cur_x_d      = cur_x_q;
		cur_y_d      = cur_y_q;
		goal_x_d     = goal_x_q;
		goal_y_d     = goal_y_q;
		span_x_d     = span_x_q;
		span_y_d     = span_y_q;
		step_x_neg_d = step_x_neg_q;
		step_y_neg_d = step_y_neg_q;
		err_d        = err_q;
		emit         = 1'b0;

		span_x_s = $signed({3'b000, span_x_q});
		span_y_s = $signed({4'b0000, span_y_q});
		err_ext  = $signed({err_q[ERR_W-1], err_q});
		e2       = $signed({err_q, 1'b0});
		err_acc  = err_ext;

		case (cmd_t'(command))
			CMD_START: begin
				emit         = 1'b1;
				cur_x_d      = start_x;
				cur_y_d      = start_y;
				goal_x_d     = end_x;
				goal_y_d     = end_y;
				span_x_d     = (end_x > start_x) ? end_x - start_x : start_x - end_x;
				span_y_d     = (end_y > start_y) ? end_y - start_y : start_y - end_y;
				step_x_neg_d = !(start_x < end_x);
				step_y_neg_d = !(start_y < end_y);
				err_d        = ERR_W'({2'b00, span_x_d}) - ERR_W'({3'b000, span_y_d});
			end
			CMD_NEXT: begin
				if (active_q) begin
					emit = 1'b1;
					// doubled error drives both the column and row decision
					if (e2 > -span_y_s) begin
						err_acc = err_acc - span_y_s;
						cur_x_d = step_x_neg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
					end
					if (e2 < span_x_s) begin
						err_acc = err_acc + span_x_s;
						cur_y_d = step_y_neg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
					end
					err_d = err_acc[ERR_W-1:0];
				end
			end
			default: ;
		endcase

		last = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);
	end

	lrgb_color u_color (
		.x      (cur_x_d),
		.y      (cur_y_d),
		.colors (colors_q),
		.color  (color)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			span_x_q     <= '0;
			span_y_q     <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			err_q        <= '0;
			active_q     <= 1'b0;
		end else if (accept && emit) begin
			cur_x_q      <= cur_x_d;
			cur_y_q      <= cur_y_d;
			goal_x_q     <= goal_x_d;
			goal_y_q     <= goal_y_d;
			span_x_q     <= span_x_d;
			span_y_q     <= span_y_d;
			step_x_neg_q <= step_x_neg_d;
			step_y_neg_q <= step_y_neg_d;
			err_q        <= err_d;
			active_q     <= !last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_x_q     <= emit ? cur_x_d : '0;
			res_y_q     <= emit ? cur_y_d : '0;
			res_color_q <= emit ? color : '0;
			res_pv_q    <= emit;
			res_last_q  <= emit && last;
		end
	end

	assign res_valid   = res_valid_q;
	assign pixel_x     = res_x_q;
	assign pixel_y     = res_y_q;
	assign pixel_color = res_color_q;
	assign pixel_valid = res_pv_q;
	assign last_pixel  = res_last_q;

	// walker goes idle exactly when the shown pixel is the line end
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_pv_q |-> (active_q == !res_last_q))
		else $error("line_active disagrees with last_pixel of pending result");

	// a start whose endpoints coincide yields a single last pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_START) && (start_x == end_x) && (start_y == end_y)
		|=> res_valid_q && res_pv_q && res_last_q && !active_q)
		else $error("single-pixel line not flagged as last");

	// next request with no line in progress gives an empty result and keeps idle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (command == CMD_NEXT) && !active_q
		|=> res_valid_q && !res_pv_q && !res_last_q && !active_q)
		else $error("idle next request produced a pixel");

	// an accepted request always leaves a result pending
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_valid_q)
		else $error("accepted request lost its result");

endmodule

`default_nettype wire

>>> tb/line_restore_with_grid_background_tb.sv
// Self-checking testbench for line_restore_with_grid_background: Bresenham walk plus grid colors.
// Directed table and random line sequences, checked by fixed values or an in-bench predictor.
// Depends on lrgb_pkg and the RTL of the walker only.
`timescale 1ns / 100ps

module line_restore_with_grid_background_tb;
	import lrgb_pkg::*;

	localparam int LIMIT      = 400000;
	localparam int HOLD_LEN   = 300;
	localparam int HOLD_AT    = 700;
	localparam int PHASE_REQS = 280;
	localparam int X_MAX      = (1 << X_W) - 1;
	localparam int Y_MAX      = (1 << Y_W) - 1;

	typedef struct packed {
		logic [X_W-1:0]     px;
		logic [Y_W-1:0]     py;
		logic [COLOR_W-1:0] color;
		logic               shown;
		logic               at_end;
	} pixel_t;

	typedef struct packed {
		cmd_t           op;
		logic [X_W-1:0] sx;
		logic [Y_W-1:0] sy;
		logic [X_W-1:0] ex;
		logic [Y_W-1:0] ey;
		logic           typed;
		pixel_t         want;
	} stim_row_t;

	localparam pixel_t NO_PIXEL = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_we = 1'b0;
	reg_idx_t             cfg_index = REG_AXIS_COLOR;
	logic [COLOR_W-1:0]   cfg_data = '0;

	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	cmd_t                 command = CMD_START;
	logic [X_W-1:0]       start_x = '0;
	logic [Y_W-1:0]       start_y = '0;
	logic [X_W-1:0]       end_x = '0;
	logic [Y_W-1:0]       end_y = '0;

	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic [X_W-1:0]       pixel_x;
	logic [Y_W-1:0]       pixel_y;
	logic [COLOR_W-1:0]   pixel_color;
	logic                 pixel_valid;
	logic                 last_pixel;

	line_restore_with_grid_background dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.pixel_valid (pixel_valid),
		.last_pixel  (last_pixel)
	);

	always #4 clk = ~clk;

	// Walker model state and current color registers
	logic [X_W-1:0]       pos_x, tgt_x, run_x;
	logic [Y_W-1:0]       pos_y, tgt_y, run_y;
	logic                 dir_x_neg, dir_y_neg, walking;
	logic signed [ERR_W-1:0] slope_err;
	logic [COLOR_W-1:0]   shade_axis = AXIS_COLOR_RST;
	logic [COLOR_W-1:0]   shade_grid = GRID_COLOR_RST;
	logic [COLOR_W-1:0]   shade_back = BACK_COLOR_RST;

	pixel_t pixels_due [$];
	int     errors = 0;
	int     sent = 0;
	int     checked = 0;
	int     lines_started = 0;
	int     idle_nexts = 0;
	int     cycles = 0;
	bit     steady = 1'b0;
	bit     held = 1'b0;

	stim_row_t plan [25] = '{
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b1, NO_PIXEL},
		'{CMD_START, 9'd0,   8'd0,   9'd0,   8'd0,   1'b1,
			'{9'd0, 8'd0, BACK_COLOR_RST, 1'b1, 1'b1}},
		'{CMD_START, 9'd511, 8'd255, 9'd511, 8'd255, 1'b1,
			'{9'd511, 8'd255, BACK_COLOR_RST, 1'b1, 1'b1}},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b1, NO_PIXEL},
		'{CMD_START, 9'd158, 8'd10,  9'd158, 8'd10,  1'b1,
			'{9'd158, 8'd10, AXIS_COLOR_RST, 1'b1, 1'b1}},
		'{CMD_START, 9'd5,   8'd122, 9'd5,   8'd122, 1'b1,
			'{9'd5, 8'd122, AXIS_COLOR_RST, 1'b1, 1'b1}},
		'{CMD_START, 9'd68,  8'd0,   9'd68,  8'd0,   1'b1,
			'{9'd68, 8'd0, GRID_COLOR_RST, 1'b1, 1'b1}},
		'{CMD_START, 9'd0,   8'd161, 9'd0,   8'd161, 1'b1,
			'{9'd0, 8'd161, GRID_COLOR_RST, 1'b1, 1'b1}},
		// diagonal through the axis cross and a grid row
		'{CMD_START, 9'd155, 8'd119, 9'd161, 8'd125, 1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		// restart mid-line, walking toward smaller x
		'{CMD_START, 9'd511, 8'd0,   9'd506, 8'd3,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		// steep line toward smaller y
		'{CMD_START, 9'd0,   8'd255, 9'd2,   8'd250, 1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL},
		'{CMD_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   1'b0, NO_PIXEL}
	};

	function automatic logic [COLOR_W-1:0] plot_shade(input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y);
		int d;
		if (int'(x) == PLOT_LEFT + PLOT_WIDTH / 2 || int'(y) == PLOT_TOP + PLOT_HEIGHT / 2)
			return shade_axis;
		for (d = 1; d < 5; d++)
			if (int'(x) == PLOT_LEFT + 1 + (d * (PLOT_WIDTH - 3)) / 5)
				return shade_grid;
		for (d = 1; d < 4; d++)
			if (int'(y) == PLOT_TOP + 1 + (d * (PLOT_HEIGHT - 3)) / 4)
				return shade_grid;
		return shade_back;
	endfunction

	function automatic pixel_t walk_pixel(input cmd_t op, input logic [X_W-1:0] sx,
			input logic [Y_W-1:0] sy, input logic [X_W-1:0] ex, input logic [Y_W-1:0] ey);
		int     acc;
		int     twice;
		pixel_t p;
		if (op == CMD_START) begin
			pos_x = sx;
			pos_y = sy;
			tgt_x = ex;
			tgt_y = ey;
			run_x = (ex > sx) ? ex - sx : sx - ex;
			run_y = (ey > sy) ? ey - sy : sy - ey;
			dir_x_neg = !(sx < ex);
			dir_y_neg = !(sy < ey);
			acc = int'(run_x) - int'(run_y);
			slope_err = acc[ERR_W-1:0];
		end else if (!walking) begin
			return NO_PIXEL;
		end else begin
			// one doubled-error sample decides both axes
			acc = int'(slope_err);
			twice = 2 * acc;
			if (twice > -int'(run_y)) begin
				acc = acc - int'(run_y);
				pos_x = dir_x_neg ? pos_x - 1'b1 : pos_x + 1'b1;
			end
			if (twice < int'(run_x)) begin
				acc = acc + int'(run_x);
				pos_y = dir_y_neg ? pos_y - 1'b1 : pos_y + 1'b1;
			end
			slope_err = acc[ERR_W-1:0];
		end
		p.px = pos_x;
		p.py = pos_y;
		p.color = plot_shade(pos_x, pos_y);
		p.shown = 1'b1;
		p.at_end = (pos_x == tgt_x) && (pos_y == tgt_y);
		walking = !p.at_end;
		return p;
	endfunction

	function automatic int clamp(input int v, input int hi);
		return (v < 0) ? 0 : (v > hi) ? hi : v;
	endfunction

	// Offer one request, predict it when it is taken
	task automatic send_request(input cmd_t op, input logic [X_W-1:0] sx,
			input logic [Y_W-1:0] sy, input logic [X_W-1:0] ex, input logic [Y_W-1:0] ey,
			input logic typed, input pixel_t want);
		int     gap;
		pixel_t got;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= op;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		do @(posedge clk); while (!cmd_ready);
		got = walk_pixel(op, sx, sy, ex, ey);
		pixels_due.push_back(typed ? want : got);
		sent++;
		if (op == CMD_START)
			lines_started++;
		else if (!got.shown)
			idle_nexts++;
	endtask

	task automatic drain;
		cmd_valid <= 1'b0;
		while (pixels_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_colors(input logic [COLOR_W-1:0] a, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_AXIS_COLOR;
		cfg_data <= a;
		@(posedge clk);
		cfg_index <= REG_GRID_COLOR;
		cfg_data <= g;
		@(posedge clk);
		cfg_index <= REG_BACK_COLOR;
		cfg_data <= b;
		@(posedge clk);
		cfg_we <= 1'b0;
		shade_axis = a;
		shade_grid = g;
		shade_back = b;
	endtask

	// Mostly whole lines started and walked to the end; some cut short, overrun or noise
	task automatic walk_random_lines(input int budget);
		int             stop_at;
		int             reach;
		int             rise;
		int             steps;
		logic [X_W-1:0] sx, ex;
		logic [Y_W-1:0] sy, ey;
		stop_at = sent + budget;
		while (sent < stop_at) begin
			if ($urandom_range(0, 9) == 0) begin
				send_request(CMD_NEXT, X_W'($urandom), Y_W'($urandom), X_W'($urandom),
					Y_W'($urandom), 1'b0, NO_PIXEL);
			end else begin
				if ($urandom_range(0, 15) == 0) begin
					sx = X_W'($urandom);
					sy = Y_W'($urandom);
					ex = X_W'($urandom);
					ey = Y_W'($urandom);
				end else begin
					sx = X_W'($urandom_range(0, 319));
					sy = Y_W'($urandom_range(0, 239));
					ex = X_W'(clamp(int'(sx) + int'($urandom_range(0, 48)) - 24, X_MAX));
					ey = Y_W'(clamp(int'(sy) + int'($urandom_range(0, 48)) - 24, Y_MAX));
				end
				send_request(CMD_START, sx, sy, ex, ey, 1'b0, NO_PIXEL);
				reach = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
				rise = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
				if (rise > reach)
					reach = rise;
				if ($urandom_range(0, 7) == 0)
					steps = int'($urandom_range(0, reach + 2));
				else
					steps = reach;
				// the request budget also cuts a long line short
				for (int k = 0; k < steps && sent < stop_at; k++)
					send_request(CMD_NEXT, X_W'($urandom), Y_W'($urandom), X_W'($urandom),
						Y_W'($urandom), 1'b0, NO_PIXEL);
			end
		end
	endtask

	// Result side: random back-pressure, one long stall, field checks
	initial begin
		int     gap;
		pixel_t want;
		wait (arst_n);
		forever begin
			if (!held && checked >= HOLD_AT) begin
				held = 1'b1;
				gap = HOLD_LEN;
			end else begin
				gap = steady ? 0 : $urandom_range(0, 11);
			end
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			checked++;
			if (pixels_due.size() == 0) begin
				$error("pixel result with no request pending");
				errors++;
			end else begin
				want = pixels_due.pop_front();
				if (pixel_x !== want.px) begin
					$error("pixel_x: expected %0d, got %0d", want.px, pixel_x);
					errors++;
				end
				if (pixel_y !== want.py) begin
					$error("pixel_y: expected %0d, got %0d", want.py, pixel_y);
					errors++;
				end
				if (pixel_color !== want.color) begin
					$error("pixel_color: expected %0h, got %0h", want.color, pixel_color);
					errors++;
				end
				if (pixel_valid !== want.shown) begin
					$error("pixel_valid: expected %0b, got %0b", want.shown, pixel_valid);
					errors++;
				end
				if (last_pixel !== want.at_end) begin
					$error("last_pixel: expected %0b, got %0b", want.at_end, last_pixel);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		pos_x = '0;
		pos_y = '0;
		tgt_x = '0;
		tgt_y = '0;
		run_x = '0;
		run_y = '0;
		dir_x_neg = 1'b0;
		dir_y_neg = 1'b0;
		slope_err = '0;
		walking = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send_request(plan[i].op, plan[i].sx, plan[i].sy, plan[i].ex, plan[i].ey,
				plan[i].typed, plan[i].want);

		load_colors(16'h0000, 16'hFFFF, 16'h0001);
		walk_random_lines(PHASE_REQS);
		load_colors(16'hFFFF, 16'h0000, 16'hFFFE);
		steady = 1'b1;
		walk_random_lines(PHASE_REQS);
		steady = 1'b0;
		load_colors(16'($urandom), 16'($urandom), 16'($urandom));
		walk_random_lines(PHASE_REQS);
		load_colors(16'hA5A5, 16'h5A5A, 16'hFFFF);
		walk_random_lines(PHASE_REQS);
		load_colors(AXIS_COLOR_RST, GRID_COLOR_RST, BACK_COLOR_RST);
		walk_random_lines(PHASE_REQS);

		drain();
		repeat (8) @(posedge clk);
		$display("Covered %0d requests: %0d line starts, %0d next requests with no line.",
			sent, lines_started, idle_nexts);
		$display("Five color settings with all-zero and all-one values, %0d results checked.",
			checked);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> line_restore_with_grid_background.f
hw/rtl/lrgb_pkg.sv
hw/rtl/lrgb_color.sv
hw/rtl/line_restore_with_grid_background.sv
tb/line_restore_with_grid_background_tb.sv
